>>> rtl/core/nrsh_pkg.sv
// Shared types for the nearest ray segment hit block.
`timescale 1ns / 1ps
`default_nettype none

package nrsh_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_TEST = 8'b0000_0100,
    S_PROD = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_SQ   = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } nrsh_state_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } nrsh_div_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/nrsh_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module nrsh_mul #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                              clk,
  input  wire  signed [COORD_WIDTH+1:0]    a,
  input  wire  signed [COORD_WIDTH+1:0]    b,
  output logic signed [2*COORD_WIDTH+3:0]  p_r
);

  // One product per cycle, available the cycle after issue.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

>>> rtl/core/nrsh_div.sv
// Two-lane restoring divider sharing one shifted divisor, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module nrsh_div #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire  [3*COORD_WIDTH+2:0]       num_x,
  input  wire  [3*COORD_WIDTH+2:0]       num_y,
  input  wire  [2*COORD_WIDTH+1:0]       dvsr,
  output nrsh_pkg::nrsh_div_sts_t        sts,
  output logic [COORD_WIDTH:0]           q_x,
  output logic [COORD_WIDTH:0]           q_y
);
  import nrsh_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int NW = 3 * W + 3;
  localparam int QW = W + 1;
  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0] n_x_r, n_y_r, ds_r;
  logic [QW-1:0] q_x_r, q_y_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic          ge_x, ge_y;

  // Trial subtraction in both lanes.
  assign ge_x = (n_x_r >= ds_r);
  assign ge_y = (n_y_r >= ds_r);

  // Control: count the quotient bits and flag the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainders, shifted divisor and quotients.
  always_ff @(posedge clk) begin
    if (start) begin
      n_x_r <= num_x;
      n_y_r <= num_y;
      ds_r  <= {1'b0, dvsr, {W{1'b0}}};
      q_x_r <= '0;
      q_y_r <= '0;
    end else if (busy_r) begin
      n_x_r <= ge_x ? (n_x_r - ds_r) : n_x_r;
      n_y_r <= ge_y ? (n_y_r - ds_r) : n_y_r;
      ds_r  <= ds_r >> 1;
      q_x_r <= {q_x_r[QW-2:0], ge_x};
      q_y_r <= {q_y_r[QW-2:0], ge_y};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign q_x      = q_x_r;
  assign q_y      = q_y_r;

endmodule

`default_nettype wire

>>> rtl/core/nearest_ray_segment_hit.sv
// Top level: sequencer, accumulators and nearest-hit state of the ray segment hit block.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat carries one ray and one wall segment in signed fixed point; the block
// keeps the nearest crossing for the current ray and delivers one result beat (found flag,
// hit point, squared distance) after the beat marked last_wall, then starts a new ray.
// A beat that misses runs the cross products and hit test before the block is ready; a beat
// that hits also runs the partial products, division, squares and update. Their length is set
// by one shared multiplier issuing the six cross products, four partial products and two
// squares in turn, and by a restoring divider that yields one quotient bit per cycle for the
// x and y offsets together. in_ready is high only while the sequencer is idle. A result
// waits in an output register, so new beats are taken while it is pending; the last beat of
// the next ray is held in its final cycle until that pending result has been taken.
module nearest_ray_segment_hit #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  signed [COORD_WIDTH-1:0]  in_ray_start_x,
  input  wire  signed [COORD_WIDTH-1:0]  in_ray_start_y,
  input  wire  signed [COORD_WIDTH-1:0]  in_ray_end_x,
  input  wire  signed [COORD_WIDTH-1:0]  in_ray_end_y,
  input  wire  signed [COORD_WIDTH-1:0]  in_wall_a_x,
  input  wire  signed [COORD_WIDTH-1:0]  in_wall_a_y,
  input  wire  signed [COORD_WIDTH-1:0]  in_wall_b_x,
  input  wire  signed [COORD_WIDTH-1:0]  in_wall_b_y,
  input  wire                            in_last_wall,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_found,
  output logic signed [COORD_WIDTH-1:0]  out_hit_x,
  output logic signed [COORD_WIDTH-1:0]  out_hit_y,
  output logic [2*COORD_WIDTH:0]         out_distance_sq
);
  import nrsh_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int MW  = W + 2;
  localparam int PRW = 2 * W + 4;
  localparam int AW  = 2 * W + 3;
  localparam int NPW = 2 * W + 1;
  localparam int PW  = 3 * W + 1;
  localparam int NW  = 3 * W + 3;
  localparam int QW  = W + 1;
  localparam int DSW = 2 * W + 2;

  nrsh_state_t state_r, state_nxt;
  logic [2:0]  kc_r, kc_nxt;

  // Latched beat and differences.
  logic signed [W-1:0] x1_r, y1_r;
  logic signed [W:0]   dxr_r, dyr_r, dxw_r, dyw_r, ox_r, oy_r;
  logic                last_r;

  // Accumulators.
  logic signed [AW-1:0] den_r, den_nxt, na_r, na_nxt, nb_r, nb_nxt;
  logic [NPW-1:0]       den_p_r, den_p_nxt, na_p_r, na_p_nxt;
  logic [W:0]           dxm_r, dxm_nxt, dym_r, dym_nxt;
  logic                 sx_r, sx_nxt, sy_r, sy_nxt;
  logic [PW-1:0]        px_r, px_nxt, py_r, py_nxt;
  logic [DSW-1:0]       d_r, d_nxt;

  // Nearest-hit state.
  logic                 have_hit_r, have_hit_nxt;
  logic [DSW-1:0]       best_d_r, best_d_nxt;
  logic signed [W-1:0]  best_x_r, best_x_nxt, best_y_r, best_y_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic signed [W-1:0]  out_hit_x_r, out_hit_x_nxt, out_hit_y_r, out_hit_y_nxt;
  logic [2*W:0]         out_dist_r, out_dist_nxt;

  // Shared units.
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PRW-1:0] mul_p;
  logic signed [AW-1:0]  mul_v;
  logic                  div_start;
  nrsh_div_sts_t         div_sts;
  logic [QW-1:0]         q_x, q_y;
  logic [NW-1:0]         div_num_x, div_num_y;

  // Sign-corrected test values.
  logic signed [AW-1:0]  den_a, na_a, nb_a;
  logic                  is_hit;
  logic signed [W:0]     hx_w, hy_w;

  logic in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign mul_v    = mul_p[AW-1:0];

  nrsh_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Divider operands: rounding to nearest is folded into the numerator.
  assign div_num_x = {1'b0, px_r, 1'b0} + NW'(den_p_r);
  assign div_num_y = {1'b0, py_r, 1'b0} + NW'(den_p_r);
  assign div_start = (state_r == S_DIV) && (kc_r == 3'd0) && !div_sts.busy;

  nrsh_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_x (div_num_x),
    .num_y (div_num_y),
    .dvsr  ({den_p_r, 1'b0}),
    .sts   (div_sts),
    .q_x   (q_x),
    .q_y   (q_y)
  );

  // Multiplier operand selection by state and step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_MUL) begin
      case (kc_r)
        3'd0: begin mul_a = {dyw_r[W], dyw_r}; mul_b = {dxr_r[W], dxr_r}; end
        3'd1: begin mul_a = {dxw_r[W], dxw_r}; mul_b = {dyr_r[W], dyr_r}; end
        3'd2: begin mul_a = {dxw_r[W], dxw_r}; mul_b = {oy_r[W], oy_r};   end
        3'd3: begin mul_a = {dyw_r[W], dyw_r}; mul_b = {ox_r[W], ox_r};   end
        3'd4: begin mul_a = {dxr_r[W], dxr_r}; mul_b = {oy_r[W], oy_r};   end
        3'd5: begin mul_a = {dyr_r[W], dyr_r}; mul_b = {ox_r[W], ox_r};   end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_PROD) begin
      case (kc_r)
        3'd0: begin mul_a = {1'b0, na_p_r[W:0]};         mul_b = {1'b0, dxm_r}; end
        3'd1: begin mul_a = {2'b00, na_p_r[2*W:W+1]};    mul_b = {1'b0, dxm_r}; end
        3'd2: begin mul_a = {1'b0, na_p_r[W:0]};         mul_b = {1'b0, dym_r}; end
        3'd3: begin mul_a = {2'b00, na_p_r[2*W:W+1]};    mul_b = {1'b0, dym_r}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_SQ) begin
      case (kc_r)
        3'd0: begin mul_a = {1'b0, q_x}; mul_b = {1'b0, q_x}; end
        3'd1: begin mul_a = {1'b0, q_y}; mul_b = {1'b0, q_y}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Hit test on the sign-corrected denominator and numerators.
  always_comb begin
    den_a  = den_r[AW-1] ? -den_r : den_r;
    na_a   = den_r[AW-1] ? -na_r  : na_r;
    nb_a   = den_r[AW-1] ? -nb_r  : nb_r;
    is_hit = (den_a != '0) && !na_a[AW-1] && (na_a <= den_a)
             && !nb_a[AW-1] && (nb_a <= den_a);
  end

  // Hit point from the signed offsets along the ray.
  assign hx_w = {x1_r[W-1], x1_r} + (sx_r ? -$signed(q_x) : $signed(q_x));
  assign hy_w = {y1_r[W-1], y1_r} + (sy_r ? -$signed(q_y) : $signed(q_y));

  // Sequencer and accumulator updates.
  always_comb begin
    state_nxt     = state_r;
    kc_nxt        = kc_r;
    den_nxt       = den_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    den_p_nxt     = den_p_r;
    na_p_nxt      = na_p_r;
    dxm_nxt       = dxm_r;
    dym_nxt       = dym_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    d_nxt         = d_r;
    have_hit_nxt  = have_hit_r;
    best_d_nxt    = best_d_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_hit_x_nxt = out_hit_x_r;
    out_hit_y_nxt = out_hit_y_r;
    out_dist_nxt  = out_dist_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MUL;
          kc_nxt    = 3'd0;
        end
      end
      S_MUL: begin
        kc_nxt = kc_r + 3'd1;
        case (kc_r)
          3'd1: den_nxt = mul_v;
          3'd2: den_nxt = den_r - mul_v;
          3'd3: na_nxt  = mul_v;
          3'd4: na_nxt  = na_r - mul_v;
          3'd5: nb_nxt  = mul_v;
          3'd6: begin
            nb_nxt    = nb_r - mul_v;
            state_nxt = S_TEST;
          end
          default: ;
        endcase
      end
      S_TEST: begin
        den_p_nxt = den_a[NPW-1:0];
        na_p_nxt  = na_a[NPW-1:0];
        sx_nxt    = dxr_r[W];
        sy_nxt    = dyr_r[W];
        dxm_nxt   = dxr_r[W] ? $unsigned(-dxr_r) : $unsigned(dxr_r);
        dym_nxt   = dyr_r[W] ? $unsigned(-dyr_r) : $unsigned(dyr_r);
        kc_nxt    = 3'd0;
        state_nxt = is_hit ? S_PROD : S_DONE;
      end
      S_PROD: begin
        kc_nxt = kc_r + 3'd1;
        case (kc_r)
          3'd1: px_nxt = {{(PW-DSW){1'b0}}, mul_p[DSW-1:0]};
          3'd2: px_nxt = px_r + {mul_p[2*W-1:0], {(W+1){1'b0}}};
          3'd3: py_nxt = {{(PW-DSW){1'b0}}, mul_p[DSW-1:0]};
          3'd4: begin
            py_nxt    = py_r + {mul_p[2*W-1:0], {(W+1){1'b0}}};
            kc_nxt    = 3'd0;
            state_nxt = S_DIV;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_start) begin
          kc_nxt = 3'd1;
        end else if (div_sts.done) begin
          kc_nxt    = 3'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        kc_nxt = kc_r + 3'd1;
        case (kc_r)
          3'd1: d_nxt = mul_p[DSW-1:0];
          3'd2: begin
            d_nxt     = d_r + mul_p[DSW-1:0];
            state_nxt = S_UPD;
          end
          default: ;
        endcase
      end
      S_UPD: begin
        // Strictly nearer hits replace the kept one; ties keep the earlier.
        if (!have_hit_r || (d_r < best_d_r)) begin
          have_hit_nxt = 1'b1;
          best_d_nxt   = d_r;
          best_x_nxt   = hx_w[W-1:0];
          best_y_nxt   = hy_w[W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          // Deliver the ray result and start the next ray from a clean state.
          out_valid_nxt = 1'b1;
          out_found_nxt = have_hit_r;
          out_hit_x_nxt = have_hit_r ? best_x_r : '0;
          out_hit_y_nxt = have_hit_r ? best_y_r : '0;
          out_dist_nxt  = have_hit_r ? best_d_r[2*W:0] : '0;
          have_hit_nxt  = 1'b0;
          best_d_nxt    = '0;
          best_x_nxt    = '0;
          best_y_nxt    = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kc_r        <= '0;
      have_hit_r  <= 1'b0;
      best_d_r    <= '0;
      best_x_r    <= '0;
      best_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kc_r        <= kc_nxt;
      have_hit_r  <= have_hit_nxt;
      best_d_r    <= best_d_nxt;
      best_x_r    <= best_x_nxt;
      best_y_r    <= best_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x1_r   <= in_ray_start_x;
      y1_r   <= in_ray_start_y;
      dxr_r  <= {in_ray_end_x[W-1], in_ray_end_x} - {in_ray_start_x[W-1], in_ray_start_x};
      dyr_r  <= {in_ray_end_y[W-1], in_ray_end_y} - {in_ray_start_y[W-1], in_ray_start_y};
      dxw_r  <= {in_wall_b_x[W-1], in_wall_b_x} - {in_wall_a_x[W-1], in_wall_a_x};
      dyw_r  <= {in_wall_b_y[W-1], in_wall_b_y} - {in_wall_a_y[W-1], in_wall_a_y};
      ox_r   <= {in_ray_start_x[W-1], in_ray_start_x} - {in_wall_a_x[W-1], in_wall_a_x};
      oy_r   <= {in_ray_start_y[W-1], in_ray_start_y} - {in_wall_a_y[W-1], in_wall_a_y};
      last_r <= in_last_wall;
    end
    den_r       <= den_nxt;
    na_r        <= na_nxt;
    nb_r        <= nb_nxt;
    den_p_r     <= den_p_nxt;
    na_p_r      <= na_p_nxt;
    dxm_r       <= dxm_nxt;
    dym_r       <= dym_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    d_r         <= d_nxt;
    out_found_r <= out_found_nxt;
    out_hit_x_r <= out_hit_x_nxt;
    out_hit_y_r <= out_hit_y_nxt;
    out_dist_r  <= out_dist_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_hit_x       = out_hit_x_r;
  assign out_hit_y       = out_hit_y_r;
  assign out_distance_sq = out_dist_r;

endmodule

`default_nettype wire
